// ===== rtl/aps_pkg.sv =====
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types, codes and helpers of the ACK pacing shaper.
// ----------------------------------------------------------------------------
package aps_pkg;

    // Action codes of an input item
    localparam logic [1:0] ACT_ACK   = 2'd0;
    localparam logic [1:0] ACT_TIMER = 2'd1;
    localparam logic [1:0] ACT_SET   = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_THRESHOLD   = 3'd0;
    localparam logic [2:0] REG_DELAYED_ACK = 3'd1;
    localparam logic [2:0] REG_QUEUE_LIMIT = 3'd2;
    localparam logic [2:0] REG_ACTIVE      = 3'd3;
    localparam logic [2:0] REG_SEG_TICKS   = 3'd4;

    // Register reset values
    localparam logic [11:0] RST_THRESHOLD = 12'd16;
    localparam logic [4:0]  RST_QLIMIT    = 5'd16;
    localparam logic [6:0]  RST_ACTIVE    = 7'd64;
    localparam logic [15:0] RST_SEG_TICKS = 16'd1200;

    // Saturation bounds of the in-flight estimate
    localparam logic signed [20:0] EST_MAX = 21'sd524287;
    localparam logic signed [20:0] EST_MIN = -21'sd524288;

    // Flows summarised per leaf of the round-robin search tree
    localparam int GRP   = 8;
    localparam int GRP_W = 3;

    typedef struct packed {
        logic [11:0] threshold_segments;
        logic        delayed_ack;
        logic [4:0]  queue_limit;
        logic [6:0]  active_flows;
        logic [15:0] segment_ticks;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] value;
    } t_cfg_wr;

    typedef struct packed {
        logic [1:0]         action;
        logic [5:0]         flow;
        logic [31:0]        packet_handle;
        logic signed [15:0] fraction_q8;
    } t_in;

    typedef struct packed {
        logic               dropped;
        logic               released;
        logic [5:0]         released_flow;
        logic [31:0]        released_handle;
        logic [17:0]        next_wait_ticks;
        logic signed [19:0] in_flight;
    } t_out;

    function automatic logic signed [19:0] est_add(input logic signed [19:0] est,
                                                   input logic signed [2:0]  delta);
        logic signed [20:0] s;
        s = $signed({est[19], est}) + $signed({{18{delta[2]}}, delta});
        if (s > EST_MAX) begin
            s = EST_MAX;
        end else if (s < EST_MIN) begin
            s = EST_MIN;
        end
        return s[19:0];
    endfunction

endpackage

// ===== rtl/aps_chan_if.sv =====
// ----------------------------------------------------------------------------
// aps_chan_if
// Valid/ready channel carrying one item of payload type T.
// ----------------------------------------------------------------------------
interface aps_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/aps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// aps_cfg_regs
// Configuration register bank, written through its own channel.
// ----------------------------------------------------------------------------
module aps_cfg_regs
    import aps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    aps_chan_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_segments <= RST_THRESHOLD;
            r_cfg.delayed_ack        <= 1'b0;
            r_cfg.queue_limit        <= RST_QLIMIT;
            r_cfg.active_flows       <= RST_ACTIVE;
            r_cfg.segment_ticks      <= RST_SEG_TICKS;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                REG_THRESHOLD:   r_cfg.threshold_segments <= i_cfg.data.value[11:0];
                REG_DELAYED_ACK: r_cfg.delayed_ack        <= i_cfg.data.value[0];
                REG_QUEUE_LIMIT: r_cfg.queue_limit        <= i_cfg.data.value[4:0];
                REG_ACTIVE:      r_cfg.active_flows       <= i_cfg.data.value[6:0];
                REG_SEG_TICKS:   r_cfg.segment_ticks      <= i_cfg.data.value;
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/aps_flow_table.sv =====
// ----------------------------------------------------------------------------
// aps_flow_table
// Per-flow queue state (seen flag, head, count) in a synchronous memory.
// ----------------------------------------------------------------------------
module aps_flow_table #(
    parameter int FLOWS = 64,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_en,
    input  logic [$clog2(FLOWS)-1:0]       i_rd_flow,
    output logic                           o_rd_seen,
    output logic [$clog2(QUEUE_DEPTH)-1:0] o_rd_head,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_rd_count,
    input  logic                           i_wr_en,
    input  logic [$clog2(FLOWS)-1:0]       i_wr_flow,
    input  logic                           i_wr_seen,
    input  logic [$clog2(QUEUE_DEPTH)-1:0] i_wr_head,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] i_wr_count,
    output logic [FLOWS-1:0]               o_nonempty
);

    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int MW = 1 + HW + CW;

    logic [MW-1:0]    r_mem [FLOWS];
    logic [MW-1:0]    r_rd;
    logic             r_rd_vld;
    logic [FLOWS-1:0] r_vld;
    logic [FLOWS-1:0] r_ne;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_flow] <= {i_wr_seen, i_wr_head, i_wr_count};
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_flow];
        end
    end

    // An entry never written since reset reads as all zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_ne     <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_flow] <= 1'b1;
                r_ne[i_wr_flow]  <= (i_wr_count != '0);
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_flow];
            end
        end
    end

    assign o_rd_seen  = r_rd_vld & r_rd[MW-1];
    assign o_rd_head  = r_rd_vld ? r_rd[CW +: HW] : '0;
    assign o_rd_count = r_rd_vld ? r_rd[CW-1:0] : '0;
    assign o_nonempty = r_ne;

endmodule

// ===== rtl/aps_ack_store.sv =====
// ----------------------------------------------------------------------------
// aps_ack_store
// Handle memory holding every flow queue, one row of slots per flow.
// ----------------------------------------------------------------------------
module aps_ack_store #(
    parameter int DEPTH = 1024,
    parameter int HANDLE_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [HANDLE_BITS-1:0]   i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [HANDLE_BITS-1:0]   o_rd_data
);

    logic [HANDLE_BITS-1:0] r_mem [DEPTH];
    logic [HANDLE_BITS-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

// ===== rtl/aps_rr_search.sv =====
// ----------------------------------------------------------------------------
// aps_rr_search
// Round-robin search for the first non-empty flow at or after the pointer.
// ----------------------------------------------------------------------------
module aps_rr_search
    import aps_pkg::*;
#(
    parameter int FLOWS = 64,
    parameter int NW = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [$clog2(FLOWS)-1:0] i_ptr,
    input  logic [NW-1:0]            i_n,
    input  logic [FLOWS-1:0]         i_nonempty,
    output logic                     o_done,
    output logic                     o_found,
    output logic [$clog2(FLOWS)-1:0] o_flow
);

    localparam int FW = $clog2(FLOWS);
    localparam int BW = $clog2(FW + 1);
    localparam int NG = (FLOWS + GRP - 1) / GRP;

    localparam logic [1:0] SR_IDLE = 2'd0;
    localparam logic [1:0] SR_MOD  = 2'd1;
    localparam logic [1:0] SR_T1   = 2'd2;
    localparam logic [1:0] SR_T2   = 2'd3;

    logic [1:0]       r_state;
    logic [FW-1:0]    r_sh;
    logic [BW-1:0]    r_cnt;
    logic [NW-1:0]    r_rem;
    logic [FW-1:0]    r_s;
    logic [NG-1:0]    r_hi_any;
    logic [NG-1:0]    r_all_any;
    logic [GRP_W-1:0] r_hi_idx  [NG];
    logic [GRP_W-1:0] r_all_idx [NG];
    logic             r_done;
    logic             r_found;
    logic [FW-1:0]    r_flow;

    logic [NW:0]      rem_t;
    logic [NW:0]      rem_n;
    logic [NG-1:0]    hi_any;
    logic [NG-1:0]    all_any;
    logic [GRP_W-1:0] hi_idx  [NG];
    logic [GRP_W-1:0] all_idx [NG];
    logic             sel_found;
    logic [FW-1:0]    sel_flow;

    // One remainder bit per cycle, used only when the pointer lies beyond
    // a flow count that has since been lowered.
    always_comb begin
        rem_t = {r_rem, r_sh[FW-1]};
        rem_n = (rem_t >= {1'b0, i_n}) ? rem_t - {1'b0, i_n} : rem_t;
    end

    // Leaf stage: first candidate in each group of flows, both from the
    // start position onwards and over all active flows.
    always_comb begin
        int idx;
        logic cand;
        for (int g = 0; g < NG; g++) begin
            hi_any[g]  = 1'b0;
            all_any[g] = 1'b0;
            hi_idx[g]  = '0;
            all_idx[g] = '0;
            for (int k = GRP - 1; k >= 0; k--) begin
                idx  = g * GRP + k;
                cand = 1'b0;
                if (idx < FLOWS) begin
                    cand = i_nonempty[idx] && (NW'(idx) < i_n);
                end
                if (cand) begin
                    all_any[g] = 1'b1;
                    all_idx[g] = GRP_W'(k);
                end
                if (cand && (FW'(idx) >= r_s)) begin
                    hi_any[g] = 1'b1;
                    hi_idx[g] = GRP_W'(k);
                end
            end
        end
    end

    always_comb begin
        logic hit_hi;
        logic hit_all;
        logic [FW-1:0] q_hi;
        logic [FW-1:0] q_all;
        hit_hi  = 1'b0;
        hit_all = 1'b0;
        q_hi    = '0;
        q_all   = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_hi_any[g]) begin
                hit_hi = 1'b1;
                q_hi   = FW'(g * GRP) + FW'(r_hi_idx[g]);
            end
            if (r_all_any[g]) begin
                hit_all = 1'b1;
                q_all   = FW'(g * GRP) + FW'(r_all_idx[g]);
            end
        end
        sel_found = hit_hi | hit_all;
        sel_flow  = hit_hi ? q_hi : q_all;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SR_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == SR_T2);
            unique case (r_state)
                SR_IDLE: begin
                    if (i_start) begin
                        if (NW'(i_ptr) >= i_n) begin
                            r_sh    <= i_ptr;
                            r_cnt   <= BW'(FW);
                            r_rem   <= '0;
                            r_state <= SR_MOD;
                        end else begin
                            r_s     <= i_ptr;
                            r_state <= SR_T1;
                        end
                    end
                end
                SR_MOD: begin
                    r_rem <= NW'(rem_n);
                    r_sh  <= r_sh << 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == BW'(1)) begin
                        r_s     <= FW'(rem_n);
                        r_state <= SR_T1;
                    end
                end
                SR_T1: begin
                    r_hi_any  <= hi_any;
                    r_all_any <= all_any;
                    r_hi_idx  <= hi_idx;
                    r_all_idx <= all_idx;
                    r_state   <= SR_T2;
                end
                SR_T2: begin
                    r_found <= sel_found;
                    r_flow  <= sel_flow;
                    r_state <= SR_IDLE;
                end
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_found = r_found;
    assign o_flow  = r_flow;

endmodule

// ===== rtl/ack_pacing_shaper.sv =====
// ----------------------------------------------------------------------------
// ack_pacing_shaper
// Paces ACK release from per-flow queues against an in-flight estimate.
// Sequence: an ACK passes S_MOD, a set S_SET, a no-op or an expiry at or above
//   the threshold goes to S_FIN, a searching expiry S_SRCH and, if a queue holds
//   an ACK, S_MOD, plus one remainder step per pointer bit when the pointer is
//   at or beyond a lowered flow count. An output stall holds the item in S_FIN.
// Throughput: one item at a time; the next is taken only back in S_IDLE, after
//   the flow table read, modify and write and the two-stage round-robin search.
// Reset: synchronous; flow state reads as empty at once, no clearing pass.
// ----------------------------------------------------------------------------
module ack_pacing_shaper
    import aps_pkg::*;
#(
    parameter int FLOWS = 64,
    parameter int QUEUE_DEPTH = 16,
    parameter int HANDLE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aps_chan_if.sink    i_in,
    aps_chan_if.source  o_out,
    aps_chan_if.sink    i_cfg
);

    localparam int FW  = $clog2(FLOWS);
    localparam int NW1 = $clog2(FLOWS + 1);
    localparam int NW  = (NW1 > 7) ? NW1 : 7;
    localparam int HW  = $clog2(QUEUE_DEPTH);
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int LW  = (CW > 5) ? CW : 5;
    localparam int SW  = CW + 1;
    localparam int DEPTH = FLOWS * QUEUE_DEPTH;
    localparam int AW  = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MOD  = 3'd1;
    localparam logic [2:0] S_SRCH = 3'd2;
    localparam logic [2:0] S_SET  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    t_cfg cfg;

    logic [2:0]         r_state;
    t_in                r_item;
    logic signed [19:0] r_est;
    logic [FW-1:0]      r_ptr;
    logic               r_started;
    logic               r_tstart_now;
    logic               r_dropped;
    logic               r_released;
    logic [FW-1:0]      r_q;
    t_out               r_out;
    logic               r_ovalid;

    logic               accept;
    logic [NW-1:0]      n_eff;
    logic [LW-1:0]      lim;
    logic               est_lt;
    logic [17:0]        wait1;
    logic [17:0]        wait2;

    logic               ft_rd_en;
    logic [FW-1:0]      ft_rd_flow;
    logic               ft_seen;
    logic [HW-1:0]      ft_head;
    logic [CW-1:0]      ft_count;
    logic               ft_wr_en;
    logic               ft_wr_seen;
    logic [HW-1:0]      ft_wr_head;
    logic [CW-1:0]      ft_wr_count;
    logic [FLOWS-1:0]   nonempty;

    logic               srch_start;
    logic               srch_done;
    logic               srch_found;
    logic [FW-1:0]      srch_flow;

    logic [FW-1:0]      mod_flow;
    logic               in_range;
    logic               has_room;
    logic [SW-1:0]      slot_sum;
    logic [HW-1:0]      slot;
    logic [HW-1:0]      head_inc;
    logic               st_wr_en;
    logic               st_rd_en;
    logic [AW-1:0]      row_base;
    logic [HANDLE_BITS-1:0] st_rd_data;
    logic [26:0]        prod;
    logic [NW-1:0]      ptr_inc;

    aps_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    always_comb begin
        if (cfg.active_flows == '0) begin
            n_eff = NW'(1);
        end else if (NW'(cfg.active_flows) > NW'(FLOWS)) begin
            n_eff = NW'(FLOWS);
        end else begin
            n_eff = NW'(cfg.active_flows);
        end
        lim = (LW'(cfg.queue_limit) > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH)
                                                         : LW'(cfg.queue_limit);
        est_lt = r_est < $signed(20'(cfg.threshold_segments));
        wait1  = 18'(cfg.segment_ticks) + (cfg.delayed_ack ? 18'(cfg.segment_ticks) : '0);
        wait2  = wait1 + 18'(cfg.segment_ticks);
    end

    assign accept      = i_in.valid && (r_state == S_IDLE);
    assign i_in.ready  = (r_state == S_IDLE);
    assign srch_start  = accept && (i_in.data.action == ACT_TIMER) && est_lt;

    // Flow table read: the arriving ACK's flow at acceptance, or the flow
    // that the search picked.
    assign ft_rd_en   = (accept && (i_in.data.action == ACT_ACK))
                     || ((r_state == S_SRCH) && srch_done && srch_found);
    assign ft_rd_flow = (r_state == S_SRCH) ? srch_flow : FW'(i_in.data.flow);

    always_comb begin
        mod_flow = (r_item.action == ACT_TIMER) ? r_q : FW'(r_item.flow);
        in_range = NW'(r_item.flow) < n_eff;
        has_room = LW'(ft_count) < lim;
        slot_sum = SW'(ft_head) + SW'(ft_count);
        if (slot_sum >= SW'(QUEUE_DEPTH)) begin
            slot_sum = slot_sum - SW'(QUEUE_DEPTH);
        end
        slot     = HW'(slot_sum);
        head_inc = (ft_head == HW'(QUEUE_DEPTH - 1)) ? '0 : ft_head + 1'b1;
        row_base = AW'(mod_flow) * AW'(QUEUE_DEPTH);
        ptr_inc  = NW'(r_q) + 1'b1;
        prod     = 27'(r_item.fraction_q8[14:0]) * 27'(cfg.threshold_segments);
    end

    always_comb begin
        ft_wr_en    = 1'b0;
        ft_wr_seen  = ft_seen;
        ft_wr_head  = ft_head;
        ft_wr_count = ft_count;
        st_wr_en    = 1'b0;
        st_rd_en    = 1'b0;
        if (r_state == S_MOD) begin
            if (r_item.action == ACT_TIMER) begin
                ft_wr_en    = 1'b1;
                ft_wr_head  = head_inc;
                ft_wr_count = ft_count - 1'b1;
                st_rd_en    = 1'b1;
            end else if (in_range) begin
                ft_wr_en   = 1'b1;
                ft_wr_seen = 1'b1;
                if (has_room) begin
                    ft_wr_count = ft_count + 1'b1;
                    st_wr_en    = 1'b1;
                end
            end
        end
    end

    aps_flow_table #(
        .FLOWS       (FLOWS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (ft_rd_en),
        .i_rd_flow  (ft_rd_flow),
        .o_rd_seen  (ft_seen),
        .o_rd_head  (ft_head),
        .o_rd_count (ft_count),
        .i_wr_en    (ft_wr_en),
        .i_wr_flow  (mod_flow),
        .i_wr_seen  (ft_wr_seen),
        .i_wr_head  (ft_wr_head),
        .i_wr_count (ft_wr_count),
        .o_nonempty (nonempty)
    );

    aps_ack_store #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (row_base + AW'(slot)),
        .i_wr_data (HANDLE_BITS'(r_item.packet_handle)),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (row_base + AW'(ft_head)),
        .o_rd_data (st_rd_data)
    );

    aps_rr_search #(
        .FLOWS (FLOWS),
        .NW    (NW)
    ) u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (srch_start),
        .i_ptr      (r_ptr),
        .i_n        (n_eff),
        .i_nonempty (nonempty),
        .o_done     (srch_done),
        .o_found    (srch_found),
        .o_flow     (srch_flow)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_est     <= '0;
            r_ptr     <= '0;
            r_started <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if ((r_state == S_FIN) && (!r_ovalid || o_out.ready)) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_item       <= i_in.data;
                        r_dropped    <= 1'b0;
                        r_released   <= 1'b0;
                        r_tstart_now <= 1'b0;
                        unique case (i_in.data.action)
                            ACT_ACK:   r_state <= S_MOD;
                            ACT_TIMER: r_state <= est_lt ? S_SRCH : S_FIN;
                            ACT_SET:   r_state <= S_SET;
                            ACT_NOP:   r_state <= S_FIN;
                        endcase
                    end
                end
                S_SRCH: begin
                    if (srch_done) begin
                        r_q     <= srch_flow;
                        r_state <= srch_found ? S_MOD : S_FIN;
                    end
                end
                S_MOD: begin
                    if (r_item.action == ACT_TIMER) begin
                        r_est      <= est_add(r_est, cfg.delayed_ack ? 3'sd3 : 3'sd2);
                        r_ptr      <= (ptr_inc == n_eff) ? '0 : FW'(ptr_inc);
                        r_released <= 1'b1;
                    end else begin
                        // The first ACK after reset starts the timer and
                        // restarts the estimate and the pointer.
                        r_started    <= 1'b1;
                        r_tstart_now <= !r_started;
                        if (!r_started) begin
                            r_ptr <= '0;
                        end
                        if (in_range && ft_seen) begin
                            r_est <= est_add(r_started ? r_est : '0,
                                             cfg.delayed_ack ? -3'sd2 : -3'sd1);
                        end else if (!r_started) begin
                            r_est <= '0;
                        end
                        r_dropped <= !in_range || !has_room;
                    end
                    r_state <= S_FIN;
                end
                S_SET: begin
                    // The product of a 15-bit fraction and a 12-bit threshold
                    // stays below the positive bound after scaling.
                    r_est   <= r_item.fraction_q8[15] ? '0 : $signed(20'(prod[26:8]));
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && (!r_ovalid || o_out.ready)) begin
            r_out.dropped         <= r_dropped;
            r_out.released        <= r_released;
            r_out.released_flow   <= r_released ? 6'(r_q) : '0;
            r_out.released_handle <= r_released ? 32'(st_rd_data) : '0;
            r_out.in_flight       <= r_est;
            unique case (r_item.action)
                ACT_ACK:   r_out.next_wait_ticks <= r_tstart_now
                                                    ? 18'(cfg.segment_ticks) : '0;
                ACT_TIMER: r_out.next_wait_ticks <= est_lt ? wait1 : wait2;
                ACT_SET:   r_out.next_wait_ticks <= '0;
                ACT_NOP:   r_out.next_wait_ticks <= '0;
            endcase
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;

    // A released flow always has a queued handle.
    a_release_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && r_item.action == ACT_TIMER) |-> (ft_count != '0))
        else $error("release from an empty flow queue");

    // The pointer lands inside the active flows after a release.
    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD && r_item.action == ACT_TIMER) |=> (NW'(r_ptr) < n_eff))
        else $error("round-robin pointer beyond the active flows");

    // The search answers only while the sequencer waits for it.
    a_search_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        srch_done |-> (r_state == S_SRCH))
        else $error("search result outside the search state");

    // Finishing an item always presents a result.
    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && (!r_ovalid || o_out.ready)) |=> (r_ovalid && r_state == S_IDLE))
        else $error("finished item did not reach the output register");

endmodule
